// ===== hw/rtl/c2s_pkg.sv =====
// Shared constants, arctangent table and gain function for the spherical converter.
`default_nettype none
package c2s_pkg;

   localparam int GUARD_BITS       = 24;
   localparam int TABLE_LEN        = 24;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int DEF_COORD_WIDTH  = 16;
   localparam int ANGLE_WIDTH      = 34;
   localparam int RADIUS_WIDTH     = 16;
   localparam int AZIMUTH_WIDTH    = 16;
   localparam int POLAR_WIDTH      = 15;

   localparam logic signed [ANGLE_WIDTH-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

   localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
   };

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [30:0] cordic_gain_q30(input int steps);
      logic [63:0] k;
      logic [63:0] f;
      k = 64'd1 << 30;
      for (int i = 0; i < TABLE_LEN; i++) begin
         if (i < steps) begin
            f = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
            k = (k * f + (64'd1 << 29)) >> 30;
         end
      end
      return k[30:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/c2s_cordic_step.sv =====
// One vectoring CORDIC micro-rotation with a fixed shift.
`default_nettype none
module c2s_cordic_step #(
   parameter int DW    = 44,
   parameter int AW    = 34,
   parameter int SHIFT = 0
) (
   input  logic signed [DW-1:0] x_i,
   input  logic signed [DW-1:0] y_i,
   input  logic signed [AW-1:0] acc_i,
   output logic signed [DW-1:0] x_o,
   output logic signed [DW-1:0] y_o,
   output logic signed [AW-1:0] acc_o
);

   localparam logic signed [AW-1:0] ANG = AW'(c2s_pkg::ATAN_Q30[SHIFT]);

   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;

   assign dx = y_i >>> SHIFT;
   assign dy = x_i >>> SHIFT;

   always_comb begin
      if (!y_i[DW-1]) begin
         x_o   = x_i + dx;
         y_o   = y_i - dy;
         acc_o = acc_i + ANG;
      end else begin
         x_o   = x_i - dx;
         y_o   = y_i + dy;
         acc_o = acc_i - ANG;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cartesian_to_spherical.sv =====
// Top level: pipelined cartesian to spherical converter (radius, azimuth, polar angle).
`default_nettype none
// Takes one signed point per cycle unless rsp_ready back-pressure stalls the pipeline,
// and returns round(sqrt(x^2+y^2+z^2)) saturated to 16 bits, azimuth atan2(y, x) and
// polar angle atan2(sqrt(x^2+y^2), z), in 2^-13 rad or 2^-6 degree units as
// csr_wr_data selects. The depth of the pipeline is set by the azimuth and polar
// CORDIC chains (one micro-rotation per stage) against the square root chain (one root
// bit per stage). The origin gives zero outputs with rsp_zero_radius set. Write the
// angle unit bit only while no request is in flight.
module cartesian_to_spherical #(
   parameter int CORDIC_STEPS = c2s_pkg::DEF_CORDIC_STEPS,
   parameter int COORD_WIDTH  = c2s_pkg::DEF_COORD_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic                                      csr_wr_data,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [COORD_WIDTH-1:0]             req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]             req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]             req_coord_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [c2s_pkg::RADIUS_WIDTH-1:0]          rsp_radius,
   output logic signed [c2s_pkg::AZIMUTH_WIDTH-1:0]  rsp_azimuth,
   output logic [c2s_pkg::POLAR_WIDTH-1:0]           rsp_polar_angle,
   output logic                                      rsp_zero_radius
);

   localparam int CW   = COORD_WIDTH;
   localparam int NS   = (CORDIC_STEPS < c2s_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                             : c2s_pkg::TABLE_LEN;
   localparam int GB   = c2s_pkg::GUARD_BITS;
   localparam int DW   = CW + GB + 4;
   localparam int AW   = c2s_pkg::ANGLE_WIDTH;
   localparam int PW   = AW + 31;
   localparam int SQW  = 2 * CW;
   localparam int RB   = CW + 1;
   localparam int SW   = 2 * RB;
   localparam int RSW  = (RB + 1 > 17) ? RB + 1 : 17;
   localparam int ZKW  = CW + 32;
   localparam int ZK_SHIFT = 30 - GB;
   localparam int CA   = 2 * NS + 3;
   localparam int CB   = 2 * NS + 4;
   localparam int RE   = RB + 3;
   localparam int LAST = (CB > RE) ? CB : RE;
   localparam int DEG_SHIFT = 48;
   localparam int RAD_SHIFT = 17;

   localparam logic [30:0] GAIN = c2s_pkg::cordic_gain_q30(NS);
   localparam logic signed [ZKW-1:0] ZK_ROUND = ZKW'(1) <<< (ZK_SHIFT - 1);
   localparam logic signed [AW-1:0] PI = c2s_pkg::PI_Q30;
   localparam logic signed [AW-1:0] RAD_ROUND = AW'(1) <<< (RAD_SHIFT - 1);
   localparam logic signed [PW-1:0] DEG_ROUND = PW'(1) <<< (DEG_SHIFT - 1);

   typedef struct packed {
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic signed [CW-1:0]  z;
      logic [SQW-1:0]        sq_x;
      logic [SQW-1:0]        sq_y;
      logic [SQW-1:0]        sq_z;
      logic signed [DW-1:0]  cx;
      logic signed [DW-1:0]  cy;
      logic signed [DW-1:0]  zk;
      logic signed [AW-1:0]  cacc;
      logic signed [AW-1:0]  az;
      logic [SW-1:0]         n;
      logic [RB+1:0]         rem;
      logic [RB-1:0]         root;
      logic [15:0]           radius;
      logic                  axis;
      logic                  zneg;
      logic                  origin;
      logic signed [AW-1:0]  az_sel;
      logic signed [AW-1:0]  pol_sel;
      logic signed [PW-1:0]  az_prod;
      logic signed [PW-1:0]  pol_prod;
      logic [15:0]           azimuth;
      logic [14:0]           polar;
   } stage_type;

   stage_type        stage_ff [LAST+1];
   stage_type        stage_in [LAST+1];
   logic [LAST:0]    valid_ff;
   logic [LAST:0]    valid_in;
   logic [LAST:0]    stage_adv;
   logic             angle_in_degrees_ff;
   logic             angle_in_degrees_in;

   assign angle_in_degrees_in = csr_wr_en ? csr_wr_data : angle_in_degrees_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_in_degrees_ff <= 1'b0;
      end else begin
         angle_in_degrees_ff <= angle_in_degrees_in;
      end
   end

   always_comb begin
      stage_in[0]   = '0;
      stage_in[0].x = req_coord_x;
      stage_in[0].y = req_coord_y;
      stage_in[0].z = req_coord_z;
   end

   assign stage_adv[LAST] = !valid_ff[LAST] || rsp_ready;
   assign valid_in[0]     = req_valid;

   for (genvar k = 0; k < LAST; k++) begin : g_adv
      assign stage_adv[k]  = !valid_ff[k] || stage_adv[k+1];
      assign valid_in[k+1] = valid_ff[k];
   end

   for (genvar k = 0; k <= LAST; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_adv[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   for (genvar k = 1; k <= LAST; k++) begin : g_stage
      if (k == 1) begin : g_prep
         logic signed [DW-1:0]  px;
         logic signed [DW-1:0]  py;
         logic signed [SQW-1:0] sqx;
         logic signed [SQW-1:0] sqy;
         logic signed [SQW-1:0] sqz;
         logic signed [ZKW-1:0] zk_prod;

         assign px      = DW'(stage_ff[0].x) <<< GB;
         assign py      = DW'(stage_ff[0].y) <<< GB;
         assign sqx     = stage_ff[0].x * stage_ff[0].x;
         assign sqy     = stage_ff[0].y * stage_ff[0].y;
         assign sqz     = stage_ff[0].z * stage_ff[0].z;
         assign zk_prod = stage_ff[0].z * $signed({1'b0, GAIN});

         always_comb begin
            stage_in[1]        = stage_ff[0];
            stage_in[1].sq_x   = $unsigned(sqx);
            stage_in[1].sq_y   = $unsigned(sqy);
            stage_in[1].sq_z   = $unsigned(sqz);
            stage_in[1].zk     = DW'((zk_prod + ZK_ROUND) >>> ZK_SHIFT);
            stage_in[1].axis   = (stage_ff[0].x == '0) && (stage_ff[0].y == '0);
            stage_in[1].origin = (stage_ff[0].x == '0) && (stage_ff[0].y == '0)
                                 && (stage_ff[0].z == '0);
            stage_in[1].zneg   = stage_ff[0].z[CW-1];
            if (stage_ff[0].x[CW-1]) begin
               stage_in[1].cx   = -px;
               stage_in[1].cy   = -py;
               stage_in[1].cacc = stage_ff[0].y[CW-1] ? -PI : PI;
            end else begin
               stage_in[1].cx   = px;
               stage_in[1].cy   = py;
               stage_in[1].cacc = '0;
            end
         end
      end else begin : g_work
         logic signed [DW-1:0] sx;
         logic signed [DW-1:0] sy;
         logic signed [AW-1:0] sacc;
         logic [RB+1:0]        dig_t;
         logic [RB+1:0]        dig_trial;
         logic [RB:0]          rr;
         logic [RSW-1:0]       rr_w;
         logic [15:0]          rad_sat;
         logic signed [PW-1:0] az_deg;
         logic signed [PW-1:0] pol_deg;
         logic signed [AW-1:0] az_rad;
         logic signed [AW-1:0] pol_rad;

         if (k >= 2 && k <= NS + 1) begin : g_az
            c2s_cordic_step #(.DW(DW), .AW(AW), .SHIFT(k - 2)) u_step (
               .x_i(stage_ff[k-1].cx), .y_i(stage_ff[k-1].cy), .acc_i(stage_ff[k-1].cacc),
               .x_o(sx), .y_o(sy), .acc_o(sacc)
            );
         end else if (k >= NS + 3 && k <= 2 * NS + 2) begin : g_pol
            c2s_cordic_step #(.DW(DW), .AW(AW), .SHIFT(k - NS - 3)) u_step (
               .x_i(stage_ff[k-1].cx), .y_i(stage_ff[k-1].cy), .acc_i(stage_ff[k-1].cacc),
               .x_o(sx), .y_o(sy), .acc_o(sacc)
            );
         end else begin : g_hold
            assign sx   = stage_ff[k-1].cx;
            assign sy   = stage_ff[k-1].cy;
            assign sacc = stage_ff[k-1].cacc;
         end

         assign dig_t     = {stage_ff[k-1].rem[RB-1:0], stage_ff[k-1].n[SW-1 -: 2]};
         assign dig_trial = {stage_ff[k-1].root, 2'b01};
         assign rr        = (RB+1)'(stage_ff[k-1].root)
                            + (RB+1)'(stage_ff[k-1].rem > (RB+2)'(stage_ff[k-1].root));
         assign rr_w      = RSW'(rr);
         assign rad_sat   = (rr_w > RSW'(65535)) ? 16'hFFFF : rr_w[15:0];
         assign az_deg    = (stage_ff[k-1].az_prod + DEG_ROUND) >>> DEG_SHIFT;
         assign pol_deg   = (stage_ff[k-1].pol_prod + DEG_ROUND) >>> DEG_SHIFT;
         assign az_rad    = (stage_ff[k-1].az_sel + RAD_ROUND) >>> RAD_SHIFT;
         assign pol_rad   = (stage_ff[k-1].pol_sel + RAD_ROUND) >>> RAD_SHIFT;

         always_comb begin
            stage_in[k]      = stage_ff[k-1];
            stage_in[k].cx   = sx;
            stage_in[k].cy   = sy;
            stage_in[k].cacc = sacc;
            if (k == 2) begin
               stage_in[k].n    = SW'(stage_ff[k-1].sq_x) + SW'(stage_ff[k-1].sq_y)
                                  + SW'(stage_ff[k-1].sq_z);
               stage_in[k].rem  = '0;
               stage_in[k].root = '0;
            end
            if (k >= 3 && k <= RB + 2) begin
               stage_in[k].n = stage_ff[k-1].n << 2;
               if (dig_t >= dig_trial) begin
                  stage_in[k].rem  = dig_t - dig_trial;
                  stage_in[k].root = {stage_ff[k-1].root[RB-2:0], 1'b1};
               end else begin
                  stage_in[k].rem  = dig_t;
                  stage_in[k].root = {stage_ff[k-1].root[RB-2:0], 1'b0};
               end
            end
            if (k == RE) begin
               stage_in[k].radius = rad_sat;
            end
            if (k == NS + 2) begin
               stage_in[k].az = stage_ff[k-1].cacc;
               if (stage_ff[k-1].zk[DW-1]) begin
                  stage_in[k].cx   = -stage_ff[k-1].zk;
                  stage_in[k].cy   = -stage_ff[k-1].cx;
                  stage_in[k].cacc = stage_ff[k-1].cx[DW-1] ? -PI : PI;
               end else begin
                  stage_in[k].cx   = stage_ff[k-1].zk;
                  stage_in[k].cy   = stage_ff[k-1].cx;
                  stage_in[k].cacc = '0;
               end
            end
            if (k == CA) begin
               stage_in[k].az_sel  = stage_ff[k-1].axis ? '0 : stage_ff[k-1].az;
               stage_in[k].pol_sel = stage_ff[k-1].axis
                                     ? (stage_ff[k-1].zneg ? PI : '0)
                                     : stage_ff[k-1].cacc;
               stage_in[k].az_prod  = stage_in[k].az_sel
                                      * $signed({1'b0, c2s_pkg::DEG_PER_RAD_Q24});
               stage_in[k].pol_prod = stage_in[k].pol_sel
                                      * $signed({1'b0, c2s_pkg::DEG_PER_RAD_Q24});
            end
            if (k == CB) begin
               if (angle_in_degrees_ff) begin
                  stage_in[k].azimuth = az_deg[15:0];
                  stage_in[k].polar   = pol_deg[PW-1] ? '0 : pol_deg[14:0];
               end else begin
                  stage_in[k].azimuth = az_rad[15:0];
                  stage_in[k].polar   = pol_rad[AW-1] ? '0 : pol_rad[14:0];
               end
            end
         end
      end
   end

   assign req_ready       = stage_adv[0];
   assign rsp_valid       = valid_ff[LAST];
   assign rsp_radius      = stage_ff[LAST].radius;
   assign rsp_azimuth     = stage_ff[LAST].azimuth;
   assign rsp_polar_angle = stage_ff[LAST].polar;
   assign rsp_zero_radius = stage_ff[LAST].origin;

`ifndef SYNTH
   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_radius |->
         rsp_radius == '0 && rsp_azimuth == '0 && rsp_polar_angle == '0)
      else $error("origin request with nonzero outputs");

   a_radius_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_radius |-> rsp_radius != '0)
      else $error("nonzero point with zero radius");

   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> &valid_ff)
      else $error("request refused while pipeline has a bubble");
`endif

endmodule
`default_nettype wire

// ===== tb/cartesian_to_spherical_checker.sv =====
// Checker for the spherical converter: predicts each result and compares it.
`timescale 1ns / 1ps
module cartesian_to_spherical_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [15:0]       rsp_radius,
   input  logic signed [15:0] rsp_azimuth,
   input  logic [14:0]       rsp_polar_angle,
   input  logic              rsp_zero_radius,
   output int                errors,
   output int                pending
);

   localparam int STEPS = c2s_pkg::DEF_CORDIC_STEPS;
   localparam longint HALF_TURN = 64'sd3373259426;
   localparam longint RAD_TO_DEG = 64'sd961263669;

   typedef struct packed {
      logic [15:0]        radius;
      logic signed [15:0] azimuth;
      logic [14:0]        polar_angle;
      logic               zero_radius;
   } sphere_type;

   sphere_type expected_points[$];
   logic    degree_mode;
   longint  gain_q30;

   function automatic longint unsigned int_sqrt(input longint unsigned val);
      longint unsigned rem, root, probe;
      rem = val;
      root = 0;
      probe = 64'd1 << 62;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic longint calc_gain();
      longint unsigned k, f;
      k = 64'd1 << 30;
      for (int i = 0; i < STEPS && i < c2s_pkg::TABLE_LEN; i++) begin
         f = int_sqrt((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
         k = (k * f + (64'd1 << 29)) >> 30;
      end
      return longint'(k);
   endfunction

   function automatic longint rotate_to_axis(inout longint mag, input longint yv);
      longint xv, acc, dx, dy;
      xv = mag;
      acc = 0;
      if (xv < 0) begin
         acc = (yv >= 0) ? HALF_TURN : -HALF_TURN;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < STEPS && i < c2s_pkg::TABLE_LEN; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv = xv + dx;
            yv = yv - dy;
            acc = acc + longint'(c2s_pkg::ATAN_Q30[i]);
         end else begin
            xv = xv - dx;
            yv = yv + dy;
            acc = acc - longint'(c2s_pkg::ATAN_Q30[i]);
         end
      end
      mag = xv;
      return acc;
   endfunction

   function automatic longint scale_angle(input longint a, input logic deg);
      if (deg)
         return (a * RAD_TO_DEG + (64'sd1 << 47)) >>> 48;
      return (a + (64'sd1 << 16)) >>> 17;
   endfunction

   function automatic sphere_type predict_sphere(input longint x, input longint y,
                                                 input longint z, input logic deg);
      sphere_type res;
      longint unsigned sq, r;
      longint az, pol, mx, zk, az_u, pol_u;
      sq = longint'(x * x + y * y + z * z);
      r = int_sqrt(sq);
      if (sq - r * r > r)
         r = r + 1;
      if (r > 65535)
         r = 65535;
      if (x == 0 && y == 0) begin
         az = 0;
         pol = (z < 0) ? HALF_TURN : 0;
      end else begin
         mx = x <<< 24;
         az = rotate_to_axis(mx, y <<< 24);
         zk = (z * gain_q30 + (64'sd1 << 5)) >>> 6;
         pol = rotate_to_axis(zk, mx);
      end
      az_u = scale_angle(az, deg);
      pol_u = scale_angle(pol, deg);
      if (pol_u < 0)
         pol_u = 0;
      res.radius = r[15:0];
      res.azimuth = az_u[15:0];
      res.polar_angle = pol_u[14:0];
      res.zero_radius = (x == 0 && y == 0 && z == 0);
      return res;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
      degree_mode = 1'b0;
      gain_q30 = calc_gain();
   end

   // sample mid-cycle: values seen here are the ones present at the next rising edge
   always @(negedge clock) begin
      sphere_type exp_pt;
      if (reset) begin
         degree_mode = 1'b0;
      end else begin
         if (csr_wr_en)
            degree_mode = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected response: radius %0d", rsp_radius);
               errors++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_radius !== exp_pt.radius) begin
                  $error("radius: expected %0d actual %0d", exp_pt.radius, rsp_radius);
                  errors++;
               end
               if (rsp_azimuth !== exp_pt.azimuth) begin
                  $error("azimuth: expected %0d actual %0d", exp_pt.azimuth, rsp_azimuth);
                  errors++;
               end
               if (rsp_polar_angle !== exp_pt.polar_angle) begin
                  $error("polar_angle: expected %0d actual %0d", exp_pt.polar_angle,
                         rsp_polar_angle);
                  errors++;
               end
               if (rsp_zero_radius !== exp_pt.zero_radius) begin
                  $error("zero_radius: expected %0d actual %0d", exp_pt.zero_radius,
                         rsp_zero_radius);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_points.push_back(predict_sphere(req_coord_x, req_coord_y,
                                                     req_coord_z, degree_mode));
      end
      pending = expected_points.size();
   end

endmodule

// ===== tb/cartesian_to_spherical_tb.sv =====
// Testbench top: drives requests and the angle unit bit, gives the verdict.
`timescale 1ns / 1ps
module cartesian_to_spherical_tb;

   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   logic signed [15:0] req_coord_x;
   logic signed [15:0] req_coord_y;
   logic signed [15:0] req_coord_z;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [15:0]       rsp_radius;
   logic signed [15:0] rsp_azimuth;
   logic [14:0]       rsp_polar_angle;
   logic              rsp_zero_radius;
   int                errors;
   int                pending;
   int                cycle_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   logic              start_hold;
   int                hold_left;

   cartesian_to_spherical i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_radius      (rsp_radius),
      .rsp_azimuth     (rsp_azimuth),
      .rsp_polar_angle (rsp_polar_angle),
      .rsp_zero_radius (rsp_zero_radius)
   );

   cartesian_to_spherical_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_radius      (rsp_radius),
      .rsp_azimuth     (rsp_azimuth),
      .rsp_polar_angle (rsp_polar_angle),
      .rsp_zero_radius (rsp_zero_radius),
      .errors          (errors),
      .pending         (pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      rsp_ready = 1'b0;
      start_hold = 1'b0;
      hold_left = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (start_hold) begin
         rsp_ready <= 1'b0;
         hold_left <= 400;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_units(input logic deg);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= deg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(5))
         0: return 16'($urandom_range(8) - 4);
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         2: return 16'($urandom_range(512) - 256);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_random(input int count);
      logic signed [15:0] x, y, z;
      repeat (count) begin
         x = random_coord();
         y = random_coord();
         z = random_coord();
         case ($urandom_range(9))
            0: begin x = 0; y = 0; end
            1: x = 0;
            2: y = 0;
            default: ;
         endcase
         send_point(x, y, z);
      end
   endtask

   task automatic send_directed();
      send_point(0, 0, 0);
      send_point(0, 0, 1);
      send_point(0, 0, -1);
      send_point(0, 0, 16'sh7fff);
      send_point(0, 0, 16'sh8000);
      send_point(1, 0, 0);
      send_point(-1, 0, 0);
      send_point(-1, -1, 0);
      send_point(-5, 3, 2);
      send_point(0, 1, 0);
      send_point(0, -1, 0);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh8000, 0, 0);
      send_point(16'sh8000, -1, 5);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_point(3, 4, 0);
      send_point(1, 1, -16'sh7fff);
      send_point(-16'sh7fff, 1, 16'sh8000);
      send_point(0, 16'sh8000, 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      write_units(1'b1);
      send_directed();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_random(320);
      write_units(1'b0);

      send_idle_pct = 52;
      rsp_stall_pct = 0;
      send_random(300);

      // hold the response side for a long stretch and keep requests coming
      send_idle_pct = 0;
      req_valid <= 1'b0;
      start_hold <= 1'b1;
      @(posedge clock);
      start_hold <= 1'b0;
      send_random(120);
      write_units(1'b1);

      send_idle_pct = 0;
      rsp_stall_pct = 52;
      send_random(300);
      write_units(1'b0);

      send_idle_pct = 6;
      rsp_stall_pct = 6;
      send_random(270);

      drain();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== cartesian_to_spherical.f =====
hw/rtl/c2s_pkg.sv
hw/rtl/c2s_cordic_step.sv
hw/rtl/cartesian_to_spherical.sv
tb/cartesian_to_spherical_checker.sv
tb/cartesian_to_spherical_tb.sv
